### rtl/core/pal_pkg.sv
// shared types and constants of the positional array list
`timescale 1ns / 1ps
package pal_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_LOCATE   = 2'd1,
    OP_RETRIEVE = 2'd2,
    OP_DELETE   = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2
  } status_e;

  // operation that every cell carries out
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_LOCATE,
    CELL_PICK
  } cell_op_e;

  // top level sequencer states
  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_state_e;

  // scanner handshake from the top level
  typedef struct packed {
    logic start;
    logic ack;
  } scan_ctrl_t;

  // cells examined per scan cycle, and the bit index width within a group
  localparam int unsigned GROUP_W    = 16;
  localparam int unsigned GROUP_BITS = 4;

endpackage

### rtl/core/pal_cell.sv
// one list cell: holds one entry and its select flag
`timescale 1ns / 1ps
module pal_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned DW  = 32,
  parameter int unsigned PW  = 10
) (
  input  logic              clk_i,
  input  pal_pkg::cell_op_e op_i,
  input  logic [PW-1:0]     pos_i,
  input  logic [PW-1:0]     len_i,
  input  logic [DW-1:0]     value_i,
  input  logic [DW-1:0]     left_i,
  input  logic [DW-1:0]     right_i,
  output logic [DW-1:0]     data_o,
  output logic              sel_o
);
  import pal_pkg::*;

  localparam logic [PW-1:0] IDX_P  = PW'(IDX);
  localparam logic [PW-1:0] IDX_P1 = PW'(IDX + 1);

  logic [DW-1:0] data_q, data_d;
  logic          sel_q, sel_d;

  always_comb begin
    data_d = data_q;
    sel_d  = sel_q;
    unique case (op_i)
      CELL_INSERT: begin
        if (IDX_P == pos_i) begin
          data_d = value_i;
        end else if (IDX_P > pos_i && IDX_P <= len_i) begin
          data_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (IDX_P >= pos_i && IDX_P1 < len_i) begin
          data_d = right_i;
        end
      end
      CELL_LOCATE: sel_d = (IDX_P < len_i) && (data_q == value_i);
      CELL_PICK:   sel_d = (IDX_P == pos_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    sel_q  <= sel_d;
  end

  assign data_o = data_q;
  assign sel_o  = sel_q;

endmodule

### rtl/core/pal_scan.sv
// group scanner: finds the first selected cell, one group per cycle
`timescale 1ns / 1ps
module pal_scan #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned DW    = 32,
  parameter int unsigned IW    = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pal_pkg::scan_ctrl_t ctrl_i,
  input  logic [DEPTH-1:0]    sel_i,
  input  logic [DW-1:0]       data_i [DEPTH],
  output logic                done_o,
  output logic                hit_o,
  output logic [IW-1:0]       idx_o,
  output logic [DW-1:0]       data_o
);
  import pal_pkg::*;

  localparam int unsigned NG  = (DEPTH + GROUP_W - 1) / GROUP_W;
  localparam int unsigned NP  = NG * GROUP_W;
  localparam int unsigned GBW = (NG > 1) ? $clog2(NG) : 1;

  logic [NP-1:0]         sel_pad;
  logic [DW-1:0]         data_pad [NP];
  logic [GROUP_W-1:0]    grp_bits;
  logic                  hit_w;
  logic [GROUP_BITS-1:0] bit_w;
  logic [IW-1:0]         idx_w;

  logic                  busy_q, done_q, hit_q;
  logic [GBW-1:0]        grp_q;
  logic [IW-1:0]         idx_q;
  logic [DW-1:0]         data_q;

  assign sel_pad = NP'(sel_i);

  for (genvar i = 0; i < NP; i++) begin : g_pad
    if (i < DEPTH) begin : g_live
      assign data_pad[i] = data_i[i];
    end else begin : g_fill
      assign data_pad[i] = '0;
    end
  end

  // lowest set flag inside the current group
  always_comb begin
    grp_bits = sel_pad[grp_q*GROUP_W +: GROUP_W];
    hit_w    = 1'b0;
    bit_w    = '0;
    for (int b = GROUP_W - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        hit_w = 1'b1;
        bit_w = GROUP_BITS'(b);
      end
    end
    idx_w = IW'(grp_q) * IW'(GROUP_W) + IW'(bit_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
      grp_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      grp_q  <= '0;
    end else if (busy_q) begin
      if (hit_w) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
        hit_q  <= 1'b1;
      end else if (grp_q == GBW'(NG - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
        hit_q  <= 1'b0;
      end else begin
        grp_q <= grp_q + 1'b1;
      end
    end else if (ctrl_i.ack) begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && hit_w) begin
      idx_q  <= idx_w;
      data_q <= data_pad[idx_w];
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;
  assign idx_o  = idx_q;
  assign data_o = data_q;

endmodule

### rtl/core/positional_array_list_unit.sv
// top level of the positional array list: cell row, scanner, sequencer
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------
//  in       | in_valid_i / in_ready_o | operation_i, value_i, slot_i
//  out      | out_valid_o/out_ready_i | status_o, found_slot_o, read_value_o, length_now_o
//
// insert, delete and every refused item need no scan: the whole cell row
// shifts at the accept edge and the result is registered at that same edge.
// locate and a valid retrieve go through a scan: the cells flag their
// matches at the accept edge, then the scanner walks the flags sixteen cells
// per cycle and stops at the first hit.
// reset clears the length and the control state; entries stay unknown until
// inserted. a result waiting on out_ready_i holds off the next item, since the
// single output register must free first; a finished scan holds the same way.
`timescale 1ns / 1ps
module positional_array_list_unit #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         slot_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         found_slot_o,
  output logic signed [31:0] read_value_o,
  output logic [7:0]         length_now_o
);
  import pal_pkg::*;

  // length counter width and a position width that also holds any slot + 1
  localparam int unsigned LW  = $clog2(DEPTH + 1);
  localparam int unsigned PW  = ((LW > 9) ? LW : 9) + 1;
  localparam int unsigned NG  = (DEPTH + GROUP_W - 1) / GROUP_W;
  localparam int unsigned IW  = $clog2(NG * GROUP_W);
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

  // sequencer and list state
  fsm_state_e      state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  op_e             op_q, op_d;

  // output register
  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [7:0]      found_q, found_d;
  logic [31:0]     rdval_q, rdval_d;
  logic [7:0]      lenout_q, lenout_d;

  // cell row wiring
  cell_op_e              cell_op;
  logic [DATA_WIDTH-1:0] cell_val;
  logic [PW-1:0]         cell_pos;
  logic [PW-1:0]         len_x;
  logic [PW-1:0]         slot_x;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      cell_sel;

  // scanner
  scan_ctrl_t            scan_ctrl;
  logic                  scan_done;
  logic                  scan_hit;
  logic [IW-1:0]         scan_idx;
  logic [DATA_WIDTH-1:0] scan_data;

  logic                  in_acc;
  logic                  out_free;
  logic                  is_full;
  logic                  ins_bad;
  logic                  pos_bad;

  assign len_x    = PW'(len_q);
  assign slot_x   = PW'(slot_i);
  assign cell_pos = slot_x - 1'b1;
  assign cell_val = DATA_WIDTH'(value_i);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == FSM_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // position checks against the current length
  assign is_full = len_x >= DEPTH_P;
  assign ins_bad = (slot_i == 8'd0) || (slot_x > len_x + 1'b1);
  assign pos_bad = (slot_i == 8'd0) || (slot_x > len_x);

  // row of cells, each handing its entry to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    pal_cell #(
      .IDX (i),
      .DW  (DATA_WIDTH),
      .PW  (PW)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .pos_i   (cell_pos),
      .len_i   (len_x),
      .value_i (cell_val),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .sel_o   (cell_sel[i])
    );
  end

  pal_scan #(
    .DEPTH (DEPTH),
    .DW    (DATA_WIDTH),
    .IW    (IW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .sel_i  (cell_sel),
    .data_i (cell_data),
    .done_o (scan_done),
    .hit_o  (scan_hit),
    .idx_o  (scan_idx),
    .data_o (scan_data)
  );

  // sequencer: immediate results for shifts and refusals, scan for reads
  always_comb begin
    state_d         = state_q;
    len_d           = len_q;
    op_d            = op_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    status_d        = status_q;
    found_d         = found_q;
    rdval_d         = rdval_q;
    lenout_d        = lenout_q;
    cell_op         = CELL_HOLD;
    scan_ctrl.start = 1'b0;
    scan_ctrl.ack   = 1'b0;

    unique case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          op_d     = op_e'(operation_i);
          status_d = ST_DONE;
          found_d  = 8'd0;
          rdval_d  = 32'd0;
          lenout_d = 8'(len_q);
          unique case (op_e'(operation_i))
            OP_INSERT: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                status_d = ST_FULL;
              end else if (ins_bad) begin
                status_d = ST_BAD_POS;
              end else begin
                cell_op  = CELL_INSERT;
                len_d    = len_q + 1'b1;
                lenout_d = 8'(len_q + 1'b1);
              end
            end
            OP_DELETE: begin
              out_valid_d = 1'b1;
              if (pos_bad) begin
                status_d = ST_BAD_POS;
              end else begin
                cell_op  = CELL_DELETE;
                len_d    = len_q - 1'b1;
                lenout_d = 8'(len_q - 1'b1);
              end
            end
            OP_RETRIEVE: begin
              if (pos_bad) begin
                out_valid_d = 1'b1;
                status_d    = ST_BAD_POS;
              end else begin
                cell_op         = CELL_PICK;
                scan_ctrl.start = 1'b1;
                state_d         = FSM_SCAN;
              end
            end
            OP_LOCATE: begin
              cell_op         = CELL_LOCATE;
              scan_ctrl.start = 1'b1;
              state_d         = FSM_SCAN;
            end
            default: ;
          endcase
        end
      end
      FSM_SCAN: begin
        // hold a finished scan until the output register can take it
        if (scan_done && out_free) begin
          scan_ctrl.ack = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = FSM_IDLE;
          if (op_q == OP_LOCATE) begin
            found_d = scan_hit ? 8'(PW'(scan_idx) + 1'b1) : 8'(len_x + 1'b1);
          end else begin
            rdval_d = 32'(signed'(scan_data));
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_INSERT;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    rdval_q  <= rdval_d;
    lenout_q <= lenout_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign found_slot_o = found_q;
  assign read_value_o = rdval_q;
  assign length_now_o = lenout_q;

endmodule
